// ===== hw/rtl/foc_current_loop_hall_sector_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef FOC_CURRENT_LOOP_HALL_SECTOR_ASSERT_SVH
`define FOC_CURRENT_LOOP_HALL_SECTOR_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FHS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/foc_hs_pkg.sv =====
package foc_hs_pkg;

	// Width of the internal value registers and of operand A of the shared multiplier.
	localparam int VW = 48;
	localparam int BW = 18;
	localparam int PW = VW + BW;
	localparam int INTEG_W = 32;
	localparam int MID_W = 12;
	localparam int GAIN_W = 16;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;
	localparam int STEP_W = 5;

	localparam logic [CFG_IW-1:0] REG_MIDPOINT = 3'd0;
	localparam logic [CFG_IW-1:0] REG_FLUX_KP = 3'd1;
	localparam logic [CFG_IW-1:0] REG_FLUX_KI = 3'd2;
	localparam logic [CFG_IW-1:0] REG_TORQUE_KP = 3'd3;
	localparam logic [CFG_IW-1:0] REG_TORQUE_KI = 3'd4;

	// Multiplier operand A selects.
	localparam logic [3:0] MA_NONE = 4'd0;
	localparam logic [3:0] MA_DIFFA = 4'd1;
	localparam logic [3:0] MA_DIFFB = 4'd2;
	localparam logic [3:0] MA_THR = 4'd3;
	localparam logic [3:0] MA_IA = 4'd4;
	localparam logic [3:0] MA_IB = 4'd5;
	localparam logic [3:0] MA_BETA = 4'd6;
	localparam logic [3:0] MA_ERRD = 4'd7;
	localparam logic [3:0] MA_ERRQ = 4'd8;
	localparam logic [3:0] MA_VD = 4'd9;
	localparam logic [3:0] MA_VQ = 4'd10;
	localparam logic [3:0] MA_VAL = 4'd11;
	localparam logic [3:0] MA_VBE = 4'd12;

	// Multiplier operand B selects.
	localparam logic [3:0] MB_NONE = 4'd0;
	localparam logic [3:0] MB_GAIN = 4'd1;
	localparam logic [3:0] MB_PCT = 4'd2;
	localparam logic [3:0] MB_INVS3 = 4'd3;
	localparam logic [3:0] MB_INVS3X2 = 4'd4;
	localparam logic [3:0] MB_COS = 4'd5;
	localparam logic [3:0] MB_SIN = 4'd6;
	localparam logic [3:0] MB_KID = 4'd7;
	localparam logic [3:0] MB_KPD = 4'd8;
	localparam logic [3:0] MB_KIQ = 4'd9;
	localparam logic [3:0] MB_KPQ = 4'd10;
	localparam logic [3:0] MB_MHALF = 4'd11;
	localparam logic [3:0] MB_S3H = 4'd12;

	// Accumulator operations.
	localparam logic [1:0] AC_HOLD = 2'd0;
	localparam logic [1:0] AC_LD = 2'd1;
	localparam logic [1:0] AC_ADD = 2'd2;
	localparam logic [1:0] AC_SUB = 2'd3;

	// Write-back destinations.
	localparam logic [4:0] WB_NONE = 5'd0;
	localparam logic [4:0] WB_IA = 5'd1;
	localparam logic [4:0] WB_IB = 5'd2;
	localparam logic [4:0] WB_IQREF = 5'd3;
	localparam logic [4:0] WB_BETA = 5'd4;
	localparam logic [4:0] WB_ID = 5'd5;
	localparam logic [4:0] WB_IQ = 5'd6;
	localparam logic [4:0] WB_ERRD = 5'd7;
	localparam logic [4:0] WB_ERRQ = 5'd8;
	localparam logic [4:0] WB_FI = 5'd9;
	localparam logic [4:0] WB_VD = 5'd10;
	localparam logic [4:0] WB_TI = 5'd11;
	localparam logic [4:0] WB_VQ = 5'd12;
	localparam logic [4:0] WB_VAL = 5'd13;
	localparam logic [4:0] WB_VBE = 5'd14;
	localparam logic [4:0] WB_VB = 5'd15;
	localparam logic [4:0] WB_VC = 5'd16;

	localparam logic signed [BW-1:0] K_INVS3 = 18'sd18919;
	localparam logic signed [BW-1:0] K_INVS3X2 = 18'sd37838;
	localparam logic signed [BW-1:0] K_MHALF = -18'sd16384;
	localparam logic signed [BW-1:0] K_S3H = 18'sd28378;

	localparam logic [STEP_W-1:0] LAST_STEP = 5'd30;

	typedef struct packed {
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic [1:0] acc_op;
		logic [4:0] wb;
	} uop_t;

	typedef struct packed {
		logic load_in;
		logic out_load;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

	function automatic logic signed [BW-1:0] hall_sin(input logic [2:0] h);
		case (h)
			3'd2: hall_sin = 18'sd28378;
			3'd3: hall_sin = -18'sd28378;
			3'd4: hall_sin = 18'sd28378;
			3'd6: hall_sin = -18'sd28378;
			default: hall_sin = 18'sd0;
		endcase
	endfunction

	function automatic logic signed [BW-1:0] hall_cos(input logic [2:0] h);
		case (h)
			3'd2: hall_cos = 18'sd16384;
			3'd3: hall_cos = 18'sd16384;
			3'd4: hall_cos = -18'sd16384;
			3'd5: hall_cos = -18'sd32767;
			3'd6: hall_cos = -18'sd16384;
			default: hall_cos = 18'sd32767;
		endcase
	endfunction

	function automatic logic signed [BW-1:0] assist_pct(input logic [2:0] lvl);
		case (lvl)
			3'd1: assist_pct = 18'sd20;
			3'd2: assist_pct = 18'sd40;
			3'd3: assist_pct = 18'sd60;
			3'd4: assist_pct = 18'sd80;
			3'd5: assist_pct = 18'sd100;
			default: assist_pct = 18'sd0;
		endcase
	endfunction

	// Microprogram. A product issued in one step is accumulated in the next,
	// and an accumulated value is written back in the step after that.
	function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
		case (step)
			5'd0: uop_at = '{MA_DIFFA, MB_GAIN, AC_HOLD, WB_NONE};
			5'd1: uop_at = '{MA_DIFFB, MB_GAIN, AC_LD, WB_NONE};
			5'd2: uop_at = '{MA_THR, MB_PCT, AC_LD, WB_IA};
			5'd3: uop_at = '{MA_NONE, MB_NONE, AC_LD, WB_IB};
			5'd4: uop_at = '{MA_IA, MB_INVS3, AC_HOLD, WB_IQREF};
			5'd5: uop_at = '{MA_IB, MB_INVS3X2, AC_LD, WB_NONE};
			5'd6: uop_at = '{MA_NONE, MB_NONE, AC_ADD, WB_NONE};
			5'd7: uop_at = '{MA_NONE, MB_NONE, AC_HOLD, WB_BETA};
			5'd8: uop_at = '{MA_IA, MB_COS, AC_HOLD, WB_NONE};
			5'd9: uop_at = '{MA_BETA, MB_SIN, AC_LD, WB_NONE};
			5'd10: uop_at = '{MA_BETA, MB_COS, AC_ADD, WB_NONE};
			5'd11: uop_at = '{MA_IA, MB_SIN, AC_LD, WB_ID};
			5'd12: uop_at = '{MA_NONE, MB_NONE, AC_SUB, WB_ERRD};
			5'd13: uop_at = '{MA_ERRD, MB_KID, AC_HOLD, WB_IQ};
			5'd14: uop_at = '{MA_ERRD, MB_KPD, AC_LD, WB_ERRQ};
			5'd15: uop_at = '{MA_ERRQ, MB_KIQ, AC_LD, WB_FI};
			5'd16: uop_at = '{MA_ERRQ, MB_KPQ, AC_LD, WB_VD};
			5'd17: uop_at = '{MA_NONE, MB_NONE, AC_LD, WB_TI};
			5'd18: uop_at = '{MA_NONE, MB_NONE, AC_HOLD, WB_VQ};
			5'd19: uop_at = '{MA_VD, MB_COS, AC_HOLD, WB_NONE};
			5'd20: uop_at = '{MA_VQ, MB_SIN, AC_LD, WB_NONE};
			5'd21: uop_at = '{MA_VD, MB_SIN, AC_SUB, WB_NONE};
			5'd22: uop_at = '{MA_VQ, MB_COS, AC_LD, WB_VAL};
			5'd23: uop_at = '{MA_NONE, MB_NONE, AC_ADD, WB_NONE};
			5'd24: uop_at = '{MA_NONE, MB_NONE, AC_HOLD, WB_VBE};
			5'd25: uop_at = '{MA_VAL, MB_MHALF, AC_HOLD, WB_NONE};
			5'd26: uop_at = '{MA_VBE, MB_S3H, AC_LD, WB_NONE};
			5'd27: uop_at = '{MA_VAL, MB_MHALF, AC_ADD, WB_NONE};
			5'd28: uop_at = '{MA_VBE, MB_S3H, AC_LD, WB_VB};
			5'd29: uop_at = '{MA_NONE, MB_NONE, AC_SUB, WB_NONE};
			5'd30: uop_at = '{MA_NONE, MB_NONE, AC_HOLD, WB_VC};
			default: uop_at = '{MA_NONE, MB_NONE, AC_HOLD, WB_NONE};
		endcase
	endfunction

endpackage

// ===== hw/rtl/foc_hs_ctrl.sv =====
module foc_hs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  foc_hs_pkg::sts_t  sts,
	output foc_hs_pkg::cmd_t  cmd
);
	import foc_hs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load_in = in_valid && (state_q == ST_IDLE);
		if (state_q == ST_RUN) begin
			cmd.uop = uop_at(step_q);
		end
		cmd.out_load = (state_q == ST_WAIT) && !sts.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q <= '0;
					end
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_WAIT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (!sts.out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/foc_hs_datapath.sv =====
module foc_hs_datapath #(
	parameter int ADC_BITS = 12,
	parameter int CURRENT_GAIN = 100,
	parameter int DRIVE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ADC_BITS-1:0]            phase_a_sample,
	input  logic [ADC_BITS-1:0]            phase_b_sample,
	input  logic [2:0]                     hall_pattern,
	input  logic [ADC_BITS-1:0]            throttle_sample,
	input  logic [2:0]                     assist_level,
	input  logic                           cfg_wen,
	input  logic [foc_hs_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [foc_hs_pkg::CFG_DW-1:0]  cfg_wdata,
	input  foc_hs_pkg::cmd_t               cmd,
	output foc_hs_pkg::sts_t               sts,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [DRIVE_BITS-1:0]          drive_a,
	output logic [DRIVE_BITS-1:0]          drive_b,
	output logic [DRIVE_BITS-1:0]          drive_c,
	output logic                           clipped
);
	import foc_hs_pkg::*;

	localparam logic signed [VW-1:0] I32_MAX = {{(VW-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
	localparam logic signed [VW-1:0] I32_MIN = {{(VW-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};
	localparam logic signed [VW-1:0] DRV_MAX =
		{{(VW-DRIVE_BITS+1){1'b0}}, {(DRIVE_BITS-1){1'b1}}};
	localparam logic signed [VW-1:0] DRV_MIN =
		{{(VW-DRIVE_BITS+1){1'b1}}, {(DRIVE_BITS-1){1'b0}}};
	localparam logic signed [PW-1:0] HALF15 = PW'(16384);
	localparam logic signed [PW-1:0] HALF8 = PW'(128);
	localparam logic signed [BW-1:0] GAIN_K = BW'(CURRENT_GAIN);

	logic [MID_W-1:0]  mid_q;
	logic [GAIN_W-1:0] kpd_q, kid_q, kpq_q, kiq_q;

	logic [ADC_BITS-1:0] pa_q, pb_q, thr_q;
	logic [2:0]          hall_q, lvl_q;

	logic signed [VW-1:0] ia_q, ib_q, beta_q, id_q, iq_q, iqref_q, errd_q, errq_q;
	logic signed [VW-1:0] vd_q, vq_q, val_q, vbe_q, vb_q, vc_q;
	logic signed [INTEG_W-1:0] fi_q, ti_q;
	logic                      clip_q;

	logic signed [VW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] p_q, acc_q;

	logic signed [PW-1:0] s15, s8, sadc;
	logic signed [VW-1:0] r15, r8, radc, integ_sum, integ_sat;
	logic                 integ_ovf;
	logic signed [INTEG_W-1:0] integ_sel;

	logic signed [VW-1:0] diff_a, diff_b;
	logic [DRIVE_BITS-1:0] ca, cb, cc;
	logic                  oa, ob, oc;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= MID_W'(2048);
			kpd_q <= GAIN_W'(256);
			kid_q <= GAIN_W'(26);
			kpq_q <= GAIN_W'(256);
			kiq_q <= GAIN_W'(26);
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MIDPOINT: mid_q <= cfg_wdata[MID_W-1:0];
				REG_FLUX_KP: kpd_q <= cfg_wdata;
				REG_FLUX_KI: kid_q <= cfg_wdata;
				REG_TORQUE_KP: kpq_q <= cfg_wdata;
				REG_TORQUE_KI: kiq_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pa_q <= phase_a_sample;
			pb_q <= phase_b_sample;
			hall_q <= hall_pattern;
			thr_q <= throttle_sample;
			lvl_q <= assist_level;
		end
	end

	assign diff_a = $signed({{(VW-ADC_BITS){1'b0}}, pa_q}) - $signed({{(VW-MID_W){1'b0}}, mid_q});
	assign diff_b = $signed({{(VW-ADC_BITS){1'b0}}, pb_q}) - $signed({{(VW-MID_W){1'b0}}, mid_q});

	always_comb begin
		case (cmd.uop.a_sel)
			MA_DIFFA: mul_a = diff_a;
			MA_DIFFB: mul_a = diff_b;
			MA_THR: mul_a = $signed({{(VW-ADC_BITS){1'b0}}, thr_q});
			MA_IA: mul_a = ia_q;
			MA_IB: mul_a = ib_q;
			MA_BETA: mul_a = beta_q;
			MA_ERRD: mul_a = errd_q;
			MA_ERRQ: mul_a = errq_q;
			MA_VD: mul_a = vd_q;
			MA_VQ: mul_a = vq_q;
			MA_VAL: mul_a = val_q;
			MA_VBE: mul_a = vbe_q;
			default: mul_a = '0;
		endcase
		case (cmd.uop.b_sel)
			MB_GAIN: mul_b = GAIN_K;
			MB_PCT: mul_b = assist_pct(lvl_q);
			MB_INVS3: mul_b = K_INVS3;
			MB_INVS3X2: mul_b = K_INVS3X2;
			MB_COS: mul_b = hall_cos(hall_q);
			MB_SIN: mul_b = hall_sin(hall_q);
			MB_KID: mul_b = $signed({2'b00, kid_q});
			MB_KPD: mul_b = $signed({2'b00, kpd_q});
			MB_KIQ: mul_b = $signed({2'b00, kiq_q});
			MB_KPQ: mul_b = $signed({2'b00, kpq_q});
			MB_MHALF: mul_b = K_MHALF;
			MB_S3H: mul_b = K_S3H;
			default: mul_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		case (cmd.uop.acc_op)
			AC_LD: acc_q <= p_q;
			AC_ADD: acc_q <= acc_q + p_q;
			AC_SUB: acc_q <= acc_q - p_q;
			default: acc_q <= acc_q;
		endcase
	end

	// s15, s8 round half up (add half an LSB, shift); sadc truncates.
	assign s15 = (acc_q + HALF15) >>> 15;
	assign s8 = (acc_q + HALF8) >>> 8;
	assign sadc = acc_q >>> ADC_BITS;
	assign r15 = s15[VW-1:0];
	assign r8 = s8[VW-1:0];
	assign radc = sadc[VW-1:0];

	assign integ_sel = (cmd.uop.wb == WB_FI || cmd.uop.wb == WB_VD) ? fi_q : ti_q;
	assign integ_sum = r8 + VW'(integ_sel);
	assign integ_ovf = (integ_sum > I32_MAX) || (integ_sum < I32_MIN);
	assign integ_sat = (integ_sum > I32_MAX) ? I32_MAX :
		((integ_sum < I32_MIN) ? I32_MIN : integ_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q <= '0;
			ti_q <= '0;
			clip_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				clip_q <= 1'b0;
			end
			case (cmd.uop.wb)
				WB_FI: begin
					fi_q <= integ_sat[INTEG_W-1:0];
					if (integ_ovf) begin
						clip_q <= 1'b1;
					end
				end
				WB_TI: begin
					ti_q <= integ_sat[INTEG_W-1:0];
					if (integ_ovf) begin
						clip_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop.wb)
			WB_IA: ia_q <= acc_q[VW-1:0];
			WB_IB: ib_q <= acc_q[VW-1:0];
			WB_IQREF: iqref_q <= radc;
			WB_BETA: beta_q <= r15;
			WB_ID: id_q <= r15;
			WB_IQ: iq_q <= r15;
			WB_ERRD: errd_q <= -id_q;
			WB_ERRQ: errq_q <= iqref_q - iq_q;
			WB_VD: vd_q <= integ_sum;
			WB_VQ: vq_q <= integ_sum;
			WB_VAL: val_q <= r15;
			WB_VBE: vbe_q <= r15;
			WB_VB: vb_q <= r15;
			WB_VC: vc_q <= r15;
			default: begin
			end
		endcase
	end

	always_comb begin
		oa = (val_q > DRV_MAX) || (val_q < DRV_MIN);
		ob = (vb_q > DRV_MAX) || (vb_q < DRV_MIN);
		oc = (vc_q > DRV_MAX) || (vc_q < DRV_MIN);
		ca = (val_q > DRV_MAX) ? DRV_MAX[DRIVE_BITS-1:0] :
			((val_q < DRV_MIN) ? DRV_MIN[DRIVE_BITS-1:0] : val_q[DRIVE_BITS-1:0]);
		cb = (vb_q > DRV_MAX) ? DRV_MAX[DRIVE_BITS-1:0] :
			((vb_q < DRV_MIN) ? DRV_MIN[DRIVE_BITS-1:0] : vb_q[DRIVE_BITS-1:0]);
		cc = (vc_q > DRV_MAX) ? DRV_MAX[DRIVE_BITS-1:0] :
			((vc_q < DRV_MIN) ? DRV_MIN[DRIVE_BITS-1:0] : vc_q[DRIVE_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			drive_a <= ca;
			drive_b <= cb;
			drive_c <= cc;
			clipped <= clip_q | oa | ob | oc;
		end
	end

	assign m_tvalid = out_valid_q;
	assign sts.out_full = out_valid_q && !m_tready;

endmodule

// ===== hw/rtl/foc_current_loop_hall_sector.sv =====
// Field-oriented current loop with the rotor angle taken from the Hall sector.
// An input transaction carries two phase-current samples, the Hall pattern, a
// throttle sample and an assist level; each one yields one output transaction
// with three saturated phase voltage commands and a clip flag. One item is in
// work at a time: after acceptance the block runs a 31-step microprogram on a
// single shared multiplier and accumulator, then loads the output register and
// is ready again, provided the previous result has been taken by then. The user
// must write registers through the cfg port only while no item is in work; the
// block itself does not enforce this.
module foc_current_loop_hall_sector #(
	parameter int ADC_BITS = 12,
	parameter int CURRENT_GAIN = 100,
	parameter int DRIVE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// phase_a_sample, phase_b_sample, hall_pattern, throttle_sample, assist_level
	input  logic [((3*ADC_BITS+6+7)/8)*8-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// drive_a, drive_b, drive_c
	output logic [((3*DRIVE_BITS+7)/8)*8-1:0]     m_tdata,
	// clipped
	output logic                                  m_tuser,
	input  logic                                  cfg_wen,
	input  logic [foc_hs_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [foc_hs_pkg::CFG_DW-1:0]         cfg_wdata
);
	import foc_hs_pkg::*;

	localparam int ODW = ((3*DRIVE_BITS+7)/8)*8;

	cmd_t cmd;
	sts_t sts;
	logic [DRIVE_BITS-1:0] drive_a, drive_b, drive_c;

	foc_hs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	foc_hs_datapath #(
		.ADC_BITS     (ADC_BITS),
		.CURRENT_GAIN (CURRENT_GAIN),
		.DRIVE_BITS   (DRIVE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.phase_a_sample  (s_tdata[ADC_BITS-1:0]),
		.phase_b_sample  (s_tdata[2*ADC_BITS-1:ADC_BITS]),
		.hall_pattern    (s_tdata[2*ADC_BITS+2:2*ADC_BITS]),
		.throttle_sample (s_tdata[3*ADC_BITS+2:2*ADC_BITS+3]),
		.assist_level    (s_tdata[3*ADC_BITS+5:3*ADC_BITS+3]),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.sts             (sts),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.drive_a         (drive_a),
		.drive_b         (drive_b),
		.drive_c         (drive_c),
		.clipped         (m_tuser)
	);

	assign m_tdata = ODW'({drive_c, drive_b, drive_a});

endmodule

// ===== hw/rtl/foc_hs_checker.sv =====
`include "foc_current_loop_hall_sector_assert.svh"

module foc_hs_checker #(
	parameter int ODW = 48
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [ODW-1:0] m_tdata,
	input logic           m_tuser
);

	`FHS_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`FHS_ASSERT(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`FHS_ASSERT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "second item taken while one is in work")
	`FHS_ASSERT(a_no_instant_result, clk, arst_n, s_tvalid && s_tready |=> !$rose(m_tvalid), "result appeared right after acceptance")
	`FHS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind foc_current_loop_hall_sector foc_hs_checker #(
	.ODW (((3*DRIVE_BITS+7)/8)*8)
) u_foc_hs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
